>>> src/ugli_pkg.sv
// ----------------------------------------------------------------------------
// ugli_pkg: shared types and constants for the uniform grid interpolator
// Default sizes, operation and clamp codes, register indexes, item structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ugli_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_LOW  = 2'd1,
    CLAMP_HIGH = 2'd2
  } clamp_t;

  typedef enum logic [1:0] {
    CFG_GRID_START   = 2'd0,
    CFG_INDEX_SCALE  = 2'd1,
    CFG_ENTRIES_USED = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t                operation;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] query_coord;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] interp_value;
    clamp_t             clamped;
  } out_item_t;

endpackage

>>> src/uniform_grid_linear_interpolator_top.sv
// ----------------------------------------------------------------------------
// uniform_grid_linear_interpolator_top: 9-stage table interpolator, 1 item/cycle
// Each query gives one result strobe at the end of the pipeline; writes give none.
// The receiver cannot stall, so the pipeline never holds; busy is low after
// reset. Sync reset clears valid bits, sets config defaults and busy high; table stays.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uniform_grid_linear_interpolator_top #(
  parameter int TABLE_DEPTH = ugli_pkg::TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = ugli_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ugli_pkg::in_item_t  in_data,
  output logic                out_valid,
  output ugli_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  import ugli_pkg::*;

  localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int N_W     = (CNT_W > 11) ? CNT_W : 11;
  localparam int IP_W    = 64 - 2 * FRAC_BITS;
  localparam int CMP_W   = (IP_W > N_W) ? IP_W : N_W;
  localparam int PROD2_W = 34 + FRAC_BITS;
  localparam int LAT     = 9;
  localparam logic [31:0] SCALE_ONE = 32'd1 << FRAC_BITS;

  // configuration registers
  logic signed [31:0] grid_start_r;
  logic [31:0]        index_scale_r;
  logic [10:0]        entries_used_r;
  logic               busy_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_start_r   <= '0;
      index_scale_r  <= SCALE_ONE;
      entries_used_r <= 11'd2;
      busy_r         <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GRID_START:   grid_start_r   <= cfg_data;
          CFG_INDEX_SCALE:  index_scale_r  <= cfg_data;
          CFG_ENTRIES_USED: entries_used_r <= cfg_data[10:0];
          default: ;
        endcase
      end
    end
  end

  // last usable entry, with the count clamped to [2, TABLE_DEPTH]
  logic [N_W-1:0] n_eu;
  logic [N_W-1:0] n_last;

  always_comb begin
    n_eu = N_W'(entries_used_r);
    if (n_eu < N_W'(2)) begin
      n_last = N_W'(1);
    end else if (n_eu > N_W'(TABLE_DEPTH)) begin
      n_last = N_W'(TABLE_DEPTH - 1);
    end else begin
      n_last = n_eu - N_W'(1);
    end
  end

  logic in_accept;
  logic q_accept;

  assign in_accept = start && !busy_r;
  assign q_accept  = in_accept && (in_data.operation == OP_QUERY);

  // pipeline valid bits and operations
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, out_valid_r;
  op_t  op1_r, op2_r, op3_r, op4_r, op5_r;

  // write payload travels down to the table stage
  logic [9:0]         idx1_r, idx2_r, idx3_r, idx4_r;
  logic signed [31:0] val1_r, val2_r, val3_r, val4_r, val5_r;

  // query datapath
  logic signed [32:0] d1_r;
  logic               neg2_r, neg3_r, neg4_r;
  logic [32:0]        mag2_r;
  logic [48:0]        pp_lo3_r, pp_hi3_r;
  logic [63:0]        prod4_r;
  logic [ADDR_W-1:0]  addr5_r;
  logic               wok5_r;
  logic [FRAC_BITS-1:0] frac5_r, frac6_r, frac7_r;
  clamp_t             cls5_r, cls6_r, cls7_r, cls8_r;
  logic signed [31:0] lo6_r, hi6_r, lo7_r, lo8_r;
  logic signed [32:0] diff7_r;
  logic signed [PROD2_W-1:0] prod8_r;
  out_item_t          out_data_r;

  logic [32:0]        mag2_nxt;
  logic [63:0]        prod4_nxt;
  logic [IP_W-1:0]    ipart;
  logic [CMP_W-1:0]   ipart_ext;
  clamp_t             cls5_nxt;
  logic [ADDR_W-1:0]  addr5_nxt;
  logic [ADDR_W-1:0]  addr_hi;
  logic signed [34:0] blend_sum;
  out_item_t          out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_accept;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      // writes end at the table stage
      v6_r        <= v5_r && (op5_r == OP_QUERY);
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      out_valid_r <= v8_r;
    end
  end

  always_comb begin
    mag2_nxt  = d1_r[32] ? 33'(-d1_r) : 33'(d1_r);
    prod4_nxt = 64'(pp_lo3_r) + (64'(pp_hi3_r) << 16);

    ipart     = prod4_r[63:2*FRAC_BITS];
    ipart_ext = CMP_W'(ipart);
    if (neg4_r && (prod4_r != 64'd0)) begin
      cls5_nxt  = CLAMP_LOW;
      addr5_nxt = '0;
    end else if (ipart_ext >= CMP_W'(n_last)) begin
      cls5_nxt  = CLAMP_HIGH;
      addr5_nxt = ADDR_W'(n_last);
    end else begin
      cls5_nxt  = CLAMP_NONE;
      addr5_nxt = ADDR_W'(ipart);
    end
  end

  // payload stages, no reset
  always_ff @(posedge clk) begin
    op1_r  <= in_data.operation;
    idx1_r <= in_data.entry_index;
    val1_r <= in_data.entry_value;
    d1_r   <= 33'(in_data.query_coord) - 33'(grid_start_r);

    op2_r  <= op1_r;
    idx2_r <= idx1_r;
    val2_r <= val1_r;
    neg2_r <= d1_r[32];
    mag2_r <= mag2_nxt;

    op3_r    <= op2_r;
    idx3_r   <= idx2_r;
    val3_r   <= val2_r;
    neg3_r   <= neg2_r;
    pp_lo3_r <= 49'(mag2_r) * 49'(index_scale_r[15:0]);
    pp_hi3_r <= 49'(mag2_r) * 49'(index_scale_r[31:16]);

    op4_r   <= op3_r;
    idx4_r  <= idx3_r;
    val4_r  <= val3_r;
    neg4_r  <= neg3_r;
    prod4_r <= prod4_nxt;

    op5_r   <= op4_r;
    val5_r  <= val4_r;
    frac5_r <= prod4_r[2*FRAC_BITS-1:FRAC_BITS];
    cls5_r  <= cls5_nxt;
    if (op4_r == OP_WRITE) begin
      addr5_r <= ADDR_W'(idx4_r);
      wok5_r  <= (32'(idx4_r) < 32'(TABLE_DEPTH));
    end else begin
      addr5_r <= addr5_nxt;
      wok5_r  <= 1'b0;
    end
  end

  // sample table: one write port, two registered read ports
  logic signed [31:0] sample_table [TABLE_DEPTH];

  assign addr_hi = (addr5_r == ADDR_W'(TABLE_DEPTH - 1)) ? addr5_r
                                                         : addr5_r + ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (v5_r && (op5_r == OP_WRITE) && wok5_r) begin
      sample_table[addr5_r] <= val5_r;
    end
    lo6_r <= sample_table[addr5_r];
    hi6_r <= sample_table[addr_hi];
  end

  always_comb begin
    blend_sum = 35'(lo8_r) + 35'(prod8_r >>> FRAC_BITS);
    out_data_nxt.clamped = cls8_r;
    if (cls8_r != CLAMP_NONE) begin
      out_data_nxt.interp_value = lo8_r;
    end else if (blend_sum > 35'sd2147483647) begin
      out_data_nxt.interp_value = 32'sh7FFF_FFFF;
    end else if (blend_sum < -35'sd2147483648) begin
      out_data_nxt.interp_value = 32'sh8000_0000;
    end else begin
      out_data_nxt.interp_value = blend_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    frac6_r <= frac5_r;
    cls6_r  <= cls5_r;

    lo7_r   <= lo6_r;
    frac7_r <= frac6_r;
    cls7_r  <= cls6_r;
    diff7_r <= 33'(hi6_r) - 33'(lo6_r);

    lo8_r   <= lo7_r;
    cls8_r  <= cls7_r;
    prod8_r <= PROD2_W'(diff7_r) * PROD2_W'($signed({1'b0, frac7_r}));

    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // every query transfer gives exactly one result
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_accept |-> ##LAT out_valid)
    else $error("query transfer produced no result");

  a_result_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(q_accept, LAT))
    else $error("result without a matching query transfer");

  a_low_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && (op5_r == OP_QUERY) && (cls5_r == CLAMP_LOW)) |-> (addr5_r == '0))
    else $error("low clamp does not read the first entry");

  a_inside_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (v5_r && (op5_r == OP_QUERY) && (cls5_r == CLAMP_NONE))
      |-> (N_W'(addr5_r) < n_last))
    else $error("interior interval beyond the last entry");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the uniform grid linear interpolator
// Loads table entries and sends coordinate queries under random start gaps;
// a scoreboard class predicts every blend and clamp code and checks each
// result strobe in order, across several grid start, scale and count settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ugli_pkg::*;

  localparam int DEPTH     = TABLE_DEPTH_DEF;
  localparam int FB        = FRAC_BITS_DEF;
  localparam int LATENCY   = 8;
  localparam int LIMIT     = 400000;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 135;

  class interp_checker;
    logic signed [31:0] sample [DEPTH];
    bit                 written [DEPTH];
    logic signed [31:0] grid_start   = '0;
    logic        [31:0] index_scale  = 32'h0001_0000;
    logic        [10:0] entries_used = 11'd2;
    out_item_t          expected_blends [$];
    int unsigned        mismatches = 0;
    int                 rd_lo, rd_hi;

    function void set_register(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        CFG_GRID_START:   grid_start   = val;
        CFG_INDEX_SCALE:  index_scale  = val;
        CFG_ENTRIES_USED: entries_used = val[10:0];
        default: ;
      endcase
    endfunction

    function out_item_t interpolate(logic signed [31:0] coord);
      longint      diff, lo, hi, blend;
      logic [63:0] mag, pos;
      longint      n;
      out_item_t   r;
      n = longint'(entries_used);
      if (n < 2) n = 2;
      if (n > DEPTH) n = DEPTH;
      diff = longint'(coord) - longint'(grid_start);
      mag  = (diff < 0) ? -diff : diff;
      pos  = mag * {32'd0, index_scale};
      if (diff < 0 && pos != 0) begin
        rd_lo = 0;
        rd_hi = 0;
        r.interp_value = sample[0];
        r.clamped      = CLAMP_LOW;
        return r;
      end
      // at or past the last entry answers the last entry
      if (longint'(pos[63:32]) >= n - 1) begin
        rd_lo = int'(n - 1);
        rd_hi = int'(n - 1);
        r.interp_value = sample[n - 1];
        r.clamped      = CLAMP_HIGH;
        return r;
      end
      rd_lo = int'(pos[63:32]);
      rd_hi = rd_lo + 1;
      lo    = longint'(sample[rd_lo]);
      hi    = longint'(sample[rd_hi]);
      // arithmetic shift floors toward minus infinity
      blend = lo + (((hi - lo) * longint'({48'd0, pos[2*FB-1:FB]})) >>> FB);
      if (blend > 64'sh7FFF_FFFF) blend = 64'sh7FFF_FFFF;
      if (blend < -64'sh8000_0000) blend = -64'sh8000_0000;
      r.interp_value = blend[31:0];
      r.clamped      = CLAMP_NONE;
      return r;
    endfunction

    // entry a query would read that holds no value yet, or -1
    function int missing_entry(logic signed [31:0] coord);
      void'(interpolate(coord));
      if (!written[rd_lo]) return rd_lo;
      if (!written[rd_hi]) return rd_hi;
      return -1;
    endfunction

    function void note_item(in_item_t it);
      if (it.operation == OP_WRITE) begin
        sample[it.entry_index]  = it.entry_value;
        written[it.entry_index] = 1'b1;
      end else begin
        expected_blends.insert(expected_blends.size(), interpolate(it.query_coord));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_blends.size() == 0) begin
        $error("unexpected result: interp_value %0d clamped %0d",
               got.interp_value, got.clamped);
        mismatches++;
        return;
      end
      want = expected_blends.pop_front();
      if (got.interp_value !== want.interp_value) begin
        $error("interp_value: expected %0d, got %0d", want.interp_value, got.interp_value);
        mismatches++;
      end
      if (got.clamped !== want.clamped) begin
        $error("clamped: expected %0d, got %0d", want.clamped, got.clamped);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        start     = 1'b0;
  logic        busy;
  in_item_t    in_data   = '0;
  logic        out_valid;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data  = '0;

  interp_checker sb = new();
  bit            idle_on = 1'b1;
  int unsigned   cycle_count = 0;

  uniform_grid_linear_interpolator_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_data);
  end

  function automatic in_item_t entry_write(int idx, logic [31:0] val);
    in_item_t it;
    it.operation   = OP_WRITE;
    it.entry_index = idx[9:0];
    it.entry_value = val;
    it.query_coord = $urandom;
    return it;
  endfunction

  function automatic in_item_t coord_query(logic [31:0] coord);
    in_item_t it;
    it.operation   = OP_QUERY;
    it.entry_index = 10'($urandom_range(DEPTH - 1));
    it.entry_value = $urandom;
    it.query_coord = coord;
    return it;
  endfunction

  // leaves start high after the transfer so back-to-back items need no edge
  task automatic send_item(in_item_t it);
    if (idle_on && $urandom_range(99) < 11) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop start, wait out every pending result, then let trailing writes retire
  task automatic settle();
    start <= 1'b0;
    while (sb.expected_blends.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    int             n_cfg, n_eff, miss;
    logic [31:0]    gs, scale, ent_word, val;
    logic [31:0]    coord;
    longint unsigned span, tmp;
    longint         off;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: table extremes, clamps on both sides, exact last-entry hit
    send_item(entry_write(0, 32'h7FFF_FFFF));
    send_item(entry_write(1, 32'h8000_0000));
    send_item(entry_write(DEPTH - 1, 32'h5A5A_A5A5));
    send_item(coord_query(32'h0000_0000));
    send_item(coord_query(32'h0000_8000));
    send_item(coord_query(32'h0000_FFFF));
    send_item(coord_query(32'h0001_0000));
    send_item(coord_query(32'h7FFF_FFFF));
    send_item(coord_query(32'hFFFF_FFFF));
    send_item(coord_query(32'h8000_0000));
    send_item(entry_write(0, 32'h8000_0000));
    send_item(entry_write(1, 32'h7FFF_FFFF));
    send_item(coord_query(32'h0000_C000));
    settle();

    // zero scale: a coordinate below the start still lands inside
    write_register(CFG_INDEX_SCALE, 32'h0000_0000);
    write_register(CFG_GRID_START, 32'h7FFF_FFFF);
    write_register(CFG_ENTRIES_USED, 32'h0000_0000);
    send_item(coord_query(32'h8000_0000));
    send_item(coord_query(32'h7FFF_FFFF));
    settle();

    // count above the table depth, largest scale and lowest start
    write_register(CFG_INDEX_SCALE, 32'hFFFF_FFFF);
    write_register(CFG_GRID_START, 32'h8000_0000);
    write_register(CFG_ENTRIES_USED, 32'h0000_07FF);
    send_item(coord_query(32'h7FFF_FFFF));
    send_item(coord_query(32'h8000_0000));
    send_item(coord_query(32'h8000_0001));
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      gs    = $urandom;
      n_cfg = $urandom_range(2, 24);
      case (phase)
        1: gs = 32'h8000_0000;
        2: gs = 32'h7FFF_FFFF;
        4: n_cfg = 0;
        5: n_cfg = 1;
        6: n_cfg = DEPTH;
        7: n_cfg = 11'h7FF;
        default: ;
      endcase
      n_eff = (n_cfg < 2) ? 2 : (n_cfg > DEPTH) ? DEPTH : n_cfg;
      tmp   = (longint'(n_eff - 1) << 32) / $urandom_range(256, 1 << 24);
      scale = (tmp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : tmp[31:0];
      case (phase)
        3: scale = 32'hFFFF_FFFF;
        4: scale = 32'h0000_0000;
        5: scale = 32'h0000_0001;
        default: ;
      endcase
      ent_word       = $urandom;
      ent_word[10:0] = n_cfg[10:0];
      write_register(CFG_GRID_START, gs);
      write_register(CFG_INDEX_SCALE, scale);
      write_register(CFG_ENTRIES_USED, ent_word);

      span = (scale == 0) ? 64'h1_0000_0000 : (longint'(n_eff - 1) << 32) / scale;
      if (span > 64'h2_0000_0000) span = 64'h2_0000_0000;
      idle_on = (phase != 2);

      for (int k = 0; k < PHASE_LEN; k++) begin
        if ($urandom_range(199) == 0) settle();
        case ($urandom_range(7))
          0: val = 32'h7FFF_FFFF;
          1: val = 32'h8000_0000;
          default: val = $urandom;
        endcase
        if ($urandom_range(99) < 35) begin
          send_item(entry_write(($urandom_range(9) == 0) ? $urandom_range(DEPTH - 1)
                                                         : $urandom_range(n_eff - 1), val));
        end else begin
          case ($urandom_range(9))
            0: coord = $urandom;
            1: coord = gs;
            default: begin
              off   = longint'({$urandom, $urandom} % (span + span / 4 + 1)) -
                      longint'(span / 8);
              tmp   = longint'($signed(gs)) + off;
              coord = tmp[31:0];
            end
          endcase
          // turn a query that would read an empty entry into a load of that entry
          miss = sb.missing_entry(coord);
          if (miss >= 0) send_item(entry_write(miss, val));
          else send_item(coord_query(coord));
        end
      end
      settle();
    end

    repeat (LATENCY) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_blends.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
